// ----- hw/rtl/three_phase_windowed_rms_unit_defines.svh -----
// Assertion macros shared by the three-phase windowed RMS unit.
// Depends on nothing; the using module must have aclk and aresetn in scope.
`ifndef THREE_PHASE_WINDOWED_RMS_UNIT_DEFINES_SVH
`define THREE_PHASE_WINDOWED_RMS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RMS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RMS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tpwr_pkg.sv -----
// Package for the three-phase windowed RMS unit: widths, register codes,
// controller states and the command/status structs. Depends on nothing.
package tpwr_pkg;

    localparam int PHASE_COUNT = 3;
    localparam int SAMPLE_BITS = 10;
    localparam int FRAC_BITS   = 4;
    localparam int OFFSET_BITS = 14;
    localparam int WINDOW_BITS = 8;
    localparam int SUM_BITS    = 36;
    localparam int RMS_BITS    = 14;
    localparam int ROOT_BITS   = SUM_BITS / 2;
    localparam int SREM_BITS   = ROOT_BITS + 3;
    localparam int MAG_BITS    = (SAMPLE_BITS + FRAC_BITS > OFFSET_BITS) ?
                                 SAMPLE_BITS + FRAC_BITS : OFFSET_BITS;
    localparam int SQUARE_BITS = 2 * MAG_BITS;

    localparam int PHASE_IDX_BITS = (PHASE_COUNT > 1) ? $clog2(PHASE_COUNT) : 1;
    localparam int ITER_BITS      = $clog2(SUM_BITS);

    localparam int S_TDATA_BITS = ((PHASE_COUNT * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((PHASE_COUNT * RMS_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [PHASE_IDX_BITS-1:0] PHASE_LAST = PHASE_IDX_BITS'(PHASE_COUNT - 1);
    localparam logic [ITER_BITS-1:0]      DIV_LAST   = ITER_BITS'(SUM_BITS - 1);
    localparam logic [ITER_BITS-1:0]      SQRT_LAST  = ITER_BITS'(ROOT_BITS - 1);

    localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = OFFSET_BITS'(7646);
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = WINDOW_BITS'(80);
    localparam logic [RMS_BITS-1:0]    RMS_MAX      = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_OFFSET_CODE   = 8'd0,
        REG_WINDOW_LENGTH = 8'd1
    } tpwr_cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV,
        ST_SQRT,
        ST_STORE,
        ST_EMIT
    } tpwr_state_t;

    typedef struct packed {
        logic                      load_sample;
        logic                      square;
        logic                      accum;
        logic                      clear_count;
        logic                      div_load;
        logic                      div_step;
        logic                      sqrt_step;
        logic                      store;
        logic                      emit;
        logic [PHASE_IDX_BITS-1:0] phase;
    } tpwr_cmd_t;

    typedef struct packed {
        logic window_hit;
        logic out_free;
    } tpwr_status_t;

endpackage

// ----- hw/rtl/tpwr_ctrl.sv -----
// Controller of the three-phase windowed RMS unit: sequences accumulation,
// division and square root per phase. Depends on tpwr_pkg and the defines header.
`include "three_phase_windowed_rms_unit_defines.svh"

module tpwr_ctrl
    import tpwr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  tpwr_status_t status,
    output tpwr_cmd_t    cmd
);

    tpwr_state_t               state_reg, state_next;
    logic [PHASE_IDX_BITS-1:0] phase_reg, phase_next;
    logic [ITER_BITS-1:0]      iter_reg,  iter_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            iter_reg  <= iter_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        iter_next  = iter_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SQUARE;
                    phase_next = '0;
                end
            end
            ST_SQUARE: state_next = ST_ACCUM;
            ST_ACCUM: begin
                if (phase_reg == PHASE_LAST) begin
                    state_next = ST_CHECK;
                    phase_next = '0;
                end else begin
                    state_next = ST_SQUARE;
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_CHECK: state_next = status.window_hit ? ST_DIV_LOAD : ST_IDLE;
            ST_DIV_LOAD: begin
                state_next = ST_DIV;
                iter_next  = '0;
            end
            ST_DIV: begin
                if (iter_reg == DIV_LAST) begin
                    state_next = ST_SQRT;
                    iter_next  = '0;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_SQRT: begin
                if (iter_reg == SQRT_LAST) begin
                    state_next = ST_STORE;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_STORE: begin
                if (phase_reg == PHASE_LAST) begin
                    state_next = ST_EMIT;
                    phase_next = '0;
                end else begin
                    state_next = ST_DIV_LOAD;
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd       = '0;
        cmd.phase = phase_reg;
        s_tready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready        = 1'b1;
                cmd.load_sample = s_tvalid;
            end
            ST_SQUARE:   cmd.square      = 1'b1;
            ST_ACCUM:    cmd.accum       = 1'b1;
            ST_CHECK:    cmd.clear_count = status.window_hit;
            ST_DIV_LOAD: cmd.div_load    = 1'b1;
            ST_DIV:      cmd.div_step    = 1'b1;
            ST_SQRT:     cmd.sqrt_step   = 1'b1;
            ST_STORE:    cmd.store       = 1'b1;
            ST_EMIT:     cmd.emit        = status.out_free;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    `RMS_ASSERT_IMPL(a_emit_only_when_free, cmd.emit, status.out_free,
        "result loaded while the output register is still occupied")
    `RMS_ASSERT_IMPL(a_phase_in_range, 1'b1, phase_reg <= PHASE_LAST,
        "phase index out of range")
    `RMS_ASSERT_NEXT(a_accept_starts_square, s_tvalid && s_tready, state_reg == ST_SQUARE,
        "accepted item did not start accumulation")

endmodule

// ----- hw/rtl/tpwr_datapath.sv -----
// Datapath of the three-phase windowed RMS unit: configuration registers,
// square sums, bit-serial divider, digit-serial square root and output register.
// Depends on tpwr_pkg and the defines header.
`include "three_phase_windowed_rms_unit_defines.svh"

module tpwr_datapath
    import tpwr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]   m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  tpwr_cmd_t                 cmd,
    output tpwr_status_t              status
);

    logic [OFFSET_BITS-1:0] offset_reg;
    logic [WINDOW_BITS-1:0] window_reg;
    logic [WINDOW_BITS-1:0] count_reg;
    logic [SAMPLE_BITS-1:0] sample_reg [PHASE_COUNT];
    logic [SQUARE_BITS-1:0] square_reg;
    logic [SUM_BITS-1:0]    sums_reg   [PHASE_COUNT];
    logic [SUM_BITS-1:0]    quo_reg;
    logic [WINDOW_BITS-1:0] drem_reg;
    logic [SREM_BITS-1:0]   srem_reg;
    logic [ROOT_BITS-1:0]   root_reg;
    logic [RMS_BITS-1:0]    hold_reg   [PHASE_COUNT];
    logic [RMS_BITS-1:0]    out_reg    [PHASE_COUNT];
    logic                   m_tvalid_reg;

    logic [MAG_BITS-1:0]    scaled;
    logic [MAG_BITS-1:0]    offset_ext;
    logic [MAG_BITS-1:0]    mag;
    logic [WINDOW_BITS-1:0] window_eff;
    logic [WINDOW_BITS:0]   dtrial;
    logic                   dge;
    logic [WINDOW_BITS:0]   ddiff;
    logic [SREM_BITS-1:0]   sshift;
    logic [SREM_BITS-1:0]   strial;
    logic                   sge;
    logic [RMS_BITS-1:0]    root_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFSET_RESET;
            window_reg <= WINDOW_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_OFFSET_CODE:   offset_reg <= cfg_data[OFFSET_BITS-1:0];
                REG_WINDOW_LENGTH: window_reg <= cfg_data[WINDOW_BITS-1:0];
                default: begin
                    offset_reg <= offset_reg;
                end
            endcase
        end
    end

    // A window length of zero behaves as a window of one.
    assign window_eff = (window_reg == '0) ? WINDOW_BITS'(1) : window_reg;
    assign status.window_hit = (count_reg >= window_eff);
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign scaled     = MAG_BITS'({sample_reg[cmd.phase], {FRAC_BITS{1'b0}}});
    assign offset_ext = MAG_BITS'(offset_reg);
    assign mag        = (scaled >= offset_ext) ? (scaled - offset_ext) : (offset_ext - scaled);

    // Restoring division by the window, one quotient bit per cycle.
    assign dtrial = {drem_reg, quo_reg[SUM_BITS-1]};
    assign dge    = (dtrial >= {1'b0, window_eff});
    assign ddiff  = dtrial - {1'b0, window_eff};

    // Integer square root, one root bit per cycle, fed from the quotient's top bits.
    assign sshift = {srem_reg[SREM_BITS-3:0], quo_reg[SUM_BITS-1:SUM_BITS-2]};
    assign strial = SREM_BITS'({root_reg, 2'b01});
    assign sge    = (sshift >= strial);

    assign root_sat = (root_reg > ROOT_BITS'(RMS_MAX)) ? RMS_MAX : root_reg[RMS_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            for (int p = 0; p < PHASE_COUNT; p++) begin
                sums_reg[p] <= '0;
            end
        end else begin
            if (cmd.load_sample) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.clear_count) begin
                count_reg <= '0;
            end
            if (cmd.accum) begin
                sums_reg[cmd.phase] <= sums_reg[cmd.phase] + SUM_BITS'(square_reg);
            end else if (cmd.div_load) begin
                sums_reg[cmd.phase] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            for (int p = 0; p < PHASE_COUNT; p++) begin
                sample_reg[p] <= s_tdata[p*SAMPLE_BITS +: SAMPLE_BITS];
            end
        end
        if (cmd.square) begin
            square_reg <= mag * mag;
        end
        if (cmd.div_load) begin
            quo_reg  <= sums_reg[cmd.phase];
            drem_reg <= '0;
            srem_reg <= '0;
            root_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg  <= {quo_reg[SUM_BITS-2:0], dge};
            drem_reg <= dge ? ddiff[WINDOW_BITS-1:0] : dtrial[WINDOW_BITS-1:0];
        end else if (cmd.sqrt_step) begin
            quo_reg  <= {quo_reg[SUM_BITS-3:0], 2'b00};
            srem_reg <= sge ? (sshift - strial) : sshift;
            root_reg <= {root_reg[ROOT_BITS-2:0], sge};
        end
        if (cmd.store) begin
            hold_reg[cmd.phase] <= root_sat;
        end
        if (cmd.emit) begin
            for (int p = 0; p < PHASE_COUNT; p++) begin
                out_reg[p] <= hold_reg[p];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        m_tdata = '0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            m_tdata[p*RMS_BITS +: RMS_BITS] = out_reg[p];
        end
    end

    `RMS_ASSERT_NEXT(a_emit_sets_valid, cmd.emit, m_tvalid_reg,
        "emitted result did not reach the output register")
    `RMS_ASSERT_NEXT(a_count_clear_before_div, cmd.div_load, count_reg == '0,
        "division started without clearing the sample count")
    `RMS_ASSERT_NEXT(a_sqrt_rem_bound, cmd.sqrt_step,
        srem_reg <= SREM_BITS'({root_reg, 1'b0}),
        "square root remainder exceeds twice the partial root")

endmodule

// ----- hw/rtl/three_phase_windowed_rms_unit.sv -----
// Top level of the three-phase windowed RMS unit: controller plus datapath.
// Depends on tpwr_pkg, tpwr_ctrl and tpwr_datapath.
//
//  Channel  Dir  Handshake            Payload
//  s_       in   s_tvalid/s_tready    s_tdata: sample_a, sample_b, sample_c
//  m_       out  m_tvalid/m_tready    m_tdata: rms_a, rms_b, rms_c
//  cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An item that does not close a window takes these steps: accept, a square and an
// accumulate step per phase, and a window check.
// The item that closes a window then runs, per phase, a load, the divider steps
// and the square root steps plus a store, all on one shared unit.
// The result waits in an output register; a stalled m_tready delays only that step.
// aresetn is synchronous and active low; it restores the register defaults.

module three_phase_windowed_rms_unit
    import tpwr_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_TDATA_BITS-1:0]   s_tdata,   // sample_a, sample_b, sample_c, zero fill
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_TDATA_BITS-1:0]   m_tdata,   // rms_a, rms_b, rms_c, zero fill
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    tpwr_cmd_t    cmd;
    tpwr_status_t status;

    tpwr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tpwr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for three_phase_windowed_rms_unit: directed rows, then random
// windows. Depends on tpwr_pkg and the RTL of three_phase_windowed_rms_unit.
module tb_top;
    import tpwr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int SETTLE_CYCLES   = 200;
    localparam int PRESS_CYCLES    = 600;
    localparam int ITEM_TARGET     = 1330;
    localparam int CALM_ITEMS      = 150;
    localparam int DIRECTED_COUNT  = 34;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNKNOWN_LOW = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNKNOWN_TOP = 8'd255;

    typedef logic [SAMPLE_BITS-1:0] code_t;
    typedef logic [RMS_BITS-1:0]    rms_t;

    typedef struct packed {
        rms_t rms_c;
        rms_t rms_b;
        rms_t rms_a;
    } rms_triple_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                 kind;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
        code_t                     a;
        code_t                     b;
        code_t                     c;
        logic                      typed;
        rms_t                      ea;
        rms_t                      eb;
        rms_t                      ec;
    } directed_row_t;

    // Rows with a typed result can be worked out by hand; the rest go through the predictor.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{ROW_SAMPLE, '0, '0, 10'd1023, 10'd0, 10'd512, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd1023, 10'd511, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd1023, 10'd1023, 10'd0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 16'd4, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd513, 10'd478, 10'd0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, REG_OFFSET_CODE, 16'd0, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 16'd1, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b1, 14'd0, 14'd0, 14'd0},
        '{ROW_SAMPLE, '0, '0, 10'd1023, 10'd1023, 10'd1023,
          1'b1, 14'd16368, 14'd16368, 14'd16368},
        '{ROW_SAMPLE, '0, '0, 10'd1023, 10'd0, 10'd1, 1'b1, 14'd16368, 14'd0, 14'd16},
        '{ROW_WRITE, REG_OFFSET_CODE, 16'd16383, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b1, 14'd16383, 14'd16383, 14'd16383},
        '{ROW_SAMPLE, '0, '0, 10'd1023, 10'd1023, 10'd1023, 1'b1, 14'd15, 14'd15, 14'd15},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 16'd0, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'h155, 10'h2AA, 10'h3FF, 1'b0, '0, '0, '0},
        '{ROW_WRITE, REG_UNKNOWN_LOW, 16'h00FF, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, REG_UNKNOWN_TOP, 16'hFFFF, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd1023, 10'd0, 1'b1, 14'd16383, 14'd15, 14'd16383},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 16'd7, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 16'd1, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd0, 10'd0, 10'd0, 1'b1, 14'd16383, 14'd16383, 14'd16383},
        '{ROW_WRITE, REG_OFFSET_CODE, 16'hDE5A, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_WRITE, REG_WINDOW_LENGTH, 16'hFF05, '0, '0, '0, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'h2AA, 10'h155, 10'h3FF, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'h155, 10'h2AA, 10'h000, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'h000, 10'h3FF, 10'h155, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'h3FF, 10'h000, 10'h2AA, 1'b0, '0, '0, '0},
        '{ROW_SAMPLE, '0, '0, 10'd512, 10'd512, 10'd512, 1'b0, '0, '0, '0}
    };

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_BITS-1:0]   s_tdata   = '0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Predictor copy of the block's registers and window state.
    logic [OFFSET_BITS-1:0] pred_offset;
    logic [WINDOW_BITS-1:0] pred_window;
    logic [SUM_BITS-1:0]    pred_sums [PHASE_COUNT];
    logic [WINDOW_BITS-1:0] pred_count;

    rms_triple_t pending_rms [$];
    int          mismatch_count = 0;
    int          items_sent     = 0;
    int          stall_cycles   = 0;
    logic        block_busy     = 1'b0;
    logic        tx_idle_on     = 1'b0;
    logic        rx_idle_on     = 1'b0;
    logic        press_go       = 1'b0;
    logic        press_done     = 1'b0;

    three_phase_windowed_rms_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] value);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = ROOT_BITS - 1; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= value) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic void predict_rms_step(input code_t a, input code_t b, input code_t c,
                                             output logic emitted, output rms_triple_t rms);
        code_t       codes [PHASE_COUNT];
        rms_t        roots [PHASE_COUNT];
        logic [63:0] scaled;
        logic [63:0] mag;
        logic [63:0] root;
        logic [63:0] span;
        codes = '{a, b, c};
        for (int p = 0; p < PHASE_COUNT; p++) begin
            scaled = 64'(codes[p]) << FRAC_BITS;
            mag = (scaled >= 64'(pred_offset)) ? scaled - 64'(pred_offset)
                                                : 64'(pred_offset) - scaled;
            pred_sums[p] = SUM_BITS'(64'(pred_sums[p]) + mag * mag);
            roots[p] = '0;
        end
        pred_count = pred_count + 1'b1;
        // A window length of zero behaves as a window of one.
        span = (pred_window == '0) ? 64'd1 : 64'(pred_window);
        emitted = 64'(pred_count) >= span;
        if (emitted) begin
            for (int p = 0; p < PHASE_COUNT; p++) begin
                root = floor_sqrt(64'(pred_sums[p]) / span);
                roots[p] = (root > 64'(RMS_MAX)) ? RMS_MAX : root[RMS_BITS-1:0];
                pred_sums[p] = '0;
            end
            pred_count = '0;
        end
        rms.rms_a = roots[0];
        rms.rms_b = roots[1];
        rms.rms_c = roots[2];
    endfunction

    function automatic code_t pick_sample(input int style);
        int centre;
        int value;
        centre = int'(pred_offset) >> FRAC_BITS;
        case (style)
            0: begin
                case ($urandom_range(0, 7))
                    0: value = 0;
                    1: value = SAMPLE_MAX;
                    default: value = $urandom_range(0, SAMPLE_MAX);
                endcase
            end
            1: begin
                value = centre + int'($urandom_range(0, 40)) - 20;
                if (value < 0) value = 0;
                if (value > SAMPLE_MAX) value = SAMPLE_MAX;
            end
            default: value = $urandom_range(0, SAMPLE_MAX);
        endcase
        return code_t'(value);
    endfunction

    task automatic note_mismatch(input string what, input logic [M_TDATA_BITS-1:0] want,
                                 input logic [M_TDATA_BITS-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    task automatic feed_sample(input code_t a, input code_t b, input code_t c,
                               input logic typed, input rms_triple_t typed_rms);
        rms_triple_t predicted;
        logic        emitted;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_BITS'({c, b, a});
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        block_busy = 1'b1;
        predict_rms_step(a, b, c, emitted, predicted);
        if (typed) begin
            pending_rms.push_back(typed_rms);
        end else if (emitted) begin
            pending_rms.push_back(predicted);
        end
    endtask

    // An item that closes no window leaves no trace in the queue, so wait out the latency too.
    task automatic settle_block();
        if (block_busy) begin
            s_tvalid <= 1'b0;
            while (pending_rms.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
            block_busy = 1'b0;
        end
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (index == REG_OFFSET_CODE) begin
            pred_offset = data[OFFSET_BITS-1:0];
        end else if (index == REG_WINDOW_LENGTH) begin
            pred_window = data[WINDOW_BITS-1:0];
        end
        @(posedge aclk);
    endtask

    // Result side: random back-pressure, plus one long hold-off to fill the block up.
    initial begin
        forever begin
            @(posedge aclk);
            if (press_go && !press_done) begin
                m_tready <= 1'b0;
                repeat (PRESS_CYCLES) @(posedge aclk);
                press_done = 1'b1;
                m_tready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        rms_triple_t want;
        rms_triple_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.rms_a = m_tdata[RMS_BITS-1:0];
            got.rms_b = m_tdata[2*RMS_BITS-1:RMS_BITS];
            got.rms_c = m_tdata[3*RMS_BITS-1:2*RMS_BITS];
            if (pending_rms.size() == 0) begin
                note_mismatch("result with no item pending", '0, m_tdata);
            end else begin
                want = pending_rms.pop_front();
                if (got.rms_a !== want.rms_a) begin
                    note_mismatch("rms_a", M_TDATA_BITS'(want.rms_a),
                                  M_TDATA_BITS'(got.rms_a));
                end
                if (got.rms_b !== want.rms_b) begin
                    note_mismatch("rms_b", M_TDATA_BITS'(want.rms_b),
                                  M_TDATA_BITS'(got.rms_b));
                end
                if (got.rms_c !== want.rms_c) begin
                    note_mismatch("rms_c", M_TDATA_BITS'(want.rms_c),
                                  M_TDATA_BITS'(got.rms_c));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("three_phase_windowed_rms_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        directed_row_t            row;
        rms_triple_t              typed_rms;
        int                       phase_no;
        int                       n_items;
        int                       span;
        int                       style;
        int                       window_value;
        int                       offset_value;
        logic                     calm;
        pred_offset = OFFSET_RESET;
        pred_window = WINDOW_RESET;
        pred_count  = '0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            pred_sums[p] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_WRITE) begin
                write_register(row.index, row.data);
            end else begin
                typed_rms.rms_a = row.ea;
                typed_rms.rms_b = row.eb;
                typed_rms.rms_c = row.ec;
                feed_sample(row.a, row.b, row.c, row.typed, typed_rms);
            end
        end

        phase_no = 0;
        typed_rms = '0;
        while (items_sent < ITEM_TARGET) begin
            phase_no++;
            calm = items_sent >= ITEM_TARGET - CALM_ITEMS;
            offset_value = $urandom_range(0, (1 << OFFSET_BITS) - 1);
            case ($urandom_range(0, 5))
                0: offset_value = 0;
                1: offset_value = (1 << OFFSET_BITS) - 1;
                2: offset_value = (SAMPLE_MAX + 1) << (FRAC_BITS - 1);
                default: ;
            endcase
            case ($urandom_range(0, 19))
                0: begin
                    offset_value = int'(OFFSET_RESET);
                    window_value = int'(WINDOW_RESET);
                end
                1:       window_value = (1 << WINDOW_BITS) - 1;
                2, 3:    window_value = 0;
                4, 5, 6: window_value = 1;
                default: window_value = $urandom_range(2, 16);
            endcase
            if (phase_no == 3) begin
                window_value = 1;
            end
            // Upper data bits beyond the register width are written too; the block drops them.
            if (phase_no <= 3 || $urandom_range(0, 3) != 0) begin
                write_register(REG_OFFSET_CODE,
                               {2'($urandom_range(0, 3)), OFFSET_BITS'(offset_value)});
            end
            write_register(REG_WINDOW_LENGTH, {8'($urandom), WINDOW_BITS'(window_value)});
            if ($urandom_range(0, 7) == 0) begin
                write_register(CFG_INDEX_BITS'($urandom_range(REG_UNKNOWN_LOW, REG_UNKNOWN_TOP)),
                               CFG_DATA_BITS'($urandom));
            end

            span = (window_value == 0) ? 1 : window_value;
            n_items = span * ((span > 32) ? 1 : int'($urandom_range(1, 4)));
            // A partial window carries over into the next setting.
            if ($urandom_range(0, 2) == 0) begin
                n_items += $urandom_range(0, span - 1);
            end
            tx_idle_on = !calm && $urandom_range(0, 3) != 0;
            rx_idle_on = !calm && $urandom_range(0, 3) != 0;
            if (phase_no == 3) begin
                n_items    = 12;
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
                press_go   = 1'b1;
            end
            style = $urandom_range(0, 2);
            for (int k = 0; k < n_items; k++) begin
                feed_sample(pick_sample(style), pick_sample(style), pick_sample(style),
                            1'b0, typed_rms);
            end
        end

        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        settle_block();
        if (mismatch_count == 0 && pending_rms.size() == 0) begin
            $display("three_phase_windowed_rms_unit test passed");
        end else begin
            $display("three_phase_windowed_rms_unit test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tpwr_pkg.sv
hw/rtl/tpwr_ctrl.sv
hw/rtl/tpwr_datapath.sv
hw/rtl/three_phase_windowed_rms_unit.sv
verif/tb_top.sv
